[design/stq_pkg.sv]
// Shared types and constants for the sorted timer queue.
// Used by stq_cell and sorted_timer_queue; depends on nothing else.
package stq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;

    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int POP_W   = $clog2(MAX_RESULTS);
    localparam int CMD_W   = 2;
    localparam int ST_W    = 2;
    localparam int KEY_W   = 16;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 32;
    localparam int DL_W    = 33;
    localparam int TV_W    = 34;

    typedef enum logic [CMD_W-1:0] {
        CMD_REQUEST = 2'd0,
        CMD_CANCEL  = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_WAIT    = 2'd3
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_NONE_DUE  = 2'd3
    } status_t;

    typedef struct packed {
        logic              insert;
        logic [DL_W-1:0]   new_dl;
        logic [KEY_W-1:0]  new_key;
        logic [KEY_W-1:0]  find_key;
        logic [TIME_W-1:0] now;
    } stq_bcast_t;

    typedef struct packed {
        logic hit;
        logic lt;
        logic due;
    } stq_flags_t;

endpackage

[design/sorted_timer_queue.sv]
// Top level of the sorted timer queue: controller, output register and the
// chain of stq_cell slots. Depends on stq_pkg and stq_cell.
//
// Timers sit in a chain of QUEUE_DEPTH cells in deadline order, equal
// deadlines in insertion order. One item is handled at a time and in_ready is
// high only while the block is idle. A request runs a key search, removal of
// an old entry with the same key and a sorted insert; on a full queue with no
// such entry it ends after the search. A tick pops due timers from the head,
// the chain moving one slot per popped timer, up to MAX_RESULTS per tick.
// Results leave through an output register; a stalled out_ready holds the
// item in progress.
module sorted_timer_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [stq_pkg::CMD_W-1:0]     command,
    input  logic [stq_pkg::KEY_W-1:0]     timer_key,
    input  logic signed [stq_pkg::DELAY_W-1:0] delay_secs,
    input  logic [stq_pkg::TIME_W-1:0]    now_secs,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [stq_pkg::ST_W-1:0]      status,
    output logic signed [stq_pkg::TV_W-1:0] time_value,
    output logic [stq_pkg::KEY_W-1:0]     expired_key,
    output logic                          last
);
    import stq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FIND   = 5'b00010,
        S_REMOVE = 5'b00100,
        S_INSERT = 5'b01000,
        S_TICK   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [POP_W-1:0] pop_reg;
    logic [POP_W-1:0] pop_next;

    cmd_t              cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DL_W-1:0]   when_reg;
    logic [TIME_W-1:0] now_reg;
    logic [DELAY_W-1:0] delay_reg;

    logic [QUEUE_DEPTH-1:0] match_reg;
    logic [DL_W-1:0]        sel_dl_reg;
    logic [DL_W-1:0]        sel_dl;

    logic                out_valid_reg;
    logic [ST_W-1:0]     status_reg;
    logic [TV_W-1:0]     tv_reg;
    logic [KEY_W-1:0]    exp_key_reg;
    logic                last_reg;
    logic                out_free;

    logic             emit;
    status_t          emit_status;
    logic [TV_W-1:0]  emit_tv;
    logic [KEY_W-1:0] emit_key;
    logic             emit_last;

    logic [QUEUE_DEPTH-1:0] shift_mask;
    logic [QUEUE_DEPTH-1:0] remove_mask;
    logic [QUEUE_DEPTH-1:0] occ;
    logic [QUEUE_DEPTH-1:0] hit_vec;
    logic                   any_hit;
    logic                   insert;
    logic                   tick_last;
    logic [DL_W-1:0]        when_in;

    stq_bcast_t  bcast;
    stq_flags_t  cell_flags [QUEUE_DEPTH];
    logic [DL_W-1:0]  cell_dl  [QUEUE_DEPTH];
    logic [KEY_W-1:0] cell_key [QUEUE_DEPTH];

    logic signed [TV_W-1:0] delay_ext;
    logic signed [TV_W-1:0] head_diff;
    logic signed [TV_W-1:0] sel_diff;
    logic signed [TV_W-1:0] wait_tv;
    logic signed [TV_W-1:0] left_tv;

    assign bcast.insert   = insert;
    assign bcast.new_dl   = when_reg;
    assign bcast.new_key  = key_reg;
    assign bcast.find_key = key_reg;
    assign bcast.now      = now_reg;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            logic              p_occ;
            logic              p_lt;
            logic [DL_W-1:0]   p_dl;
            logic [KEY_W-1:0]  p_key;
            logic [DL_W-1:0]   n_dl;
            logic [KEY_W-1:0]  n_key;

            assign occ[g]         = CNT_W'(g) < count_reg;
            assign hit_vec[g]     = cell_flags[g].hit;
            assign remove_mask[g] = |match_reg[g:0];

            if (g == 0)
            begin : g_first
                assign p_occ = 1'b1;
                assign p_lt  = 1'b0;
                assign p_dl  = '0;
                assign p_key = '0;
            end
            else
            begin : g_mid
                assign p_occ = occ[g-1];
                assign p_lt  = cell_flags[g-1].lt;
                assign p_dl  = cell_dl[g-1];
                assign p_key = cell_key[g-1];
            end

            if (g == QUEUE_DEPTH - 1)
            begin : g_end
                assign n_dl  = '0;
                assign n_key = '0;
            end
            else
            begin : g_body
                assign n_dl  = cell_dl[g+1];
                assign n_key = cell_key[g+1];
            end

            stq_cell u_cell (
                .clk        (clk),
                .bcast      (bcast),
                .shift_down (shift_mask[g]),
                .occ        (occ[g]),
                .prev_occ   (p_occ),
                .prev_lt    (p_lt),
                .prev_dl    (p_dl),
                .prev_key   (p_key),
                .next_dl    (n_dl),
                .next_key   (n_key),
                .flags      (cell_flags[g]),
                .dl         (cell_dl[g]),
                .key        (cell_key[g])
            );
        end
    endgenerate

    assign any_hit = |hit_vec;

    always_comb
    begin
        sel_dl = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            sel_dl = sel_dl | (cell_dl[i] & {DL_W{hit_vec[i]}});
        end
    end

    assign when_in = {1'b0, now_secs}
                   + {1'b0, (delay_secs[DELAY_W-1] ? {DELAY_W{1'b0}} : delay_secs)};

    assign delay_ext = {{(TV_W - DELAY_W){delay_reg[DELAY_W-1]}}, delay_reg};
    assign head_diff = $signed({1'b0, cell_dl[0]}) - $signed({2'b00, now_reg});
    assign sel_diff  = $signed({1'b0, sel_dl_reg}) - $signed({2'b00, now_reg});

    always_comb
    begin
        if (count_reg == '0)
        begin
            wait_tv = delay_reg[DELAY_W-1] ? {TV_W{1'b1}} : delay_ext;
        end
        else if (head_diff < 0)
        begin
            wait_tv = '0;
        end
        else if (!delay_reg[DELAY_W-1] && (head_diff > delay_ext))
        begin
            wait_tv = delay_ext;
        end
        else
        begin
            wait_tv = head_diff;
        end
        left_tv = (sel_diff < 0) ? '0 : sel_diff;
    end

    assign tick_last = (pop_reg == POP_W'(MAX_RESULTS - 1)) || !cell_flags[1].due;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pop_next    = pop_reg;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_tv     = '0;
        emit_key    = '0;
        emit_last   = 1'b1;
        insert      = 1'b0;
        shift_mask  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                pop_next = '0;
                if (in_valid)
                begin
                    state_next = (cmd_t'(command) == CMD_TICK) ? S_TICK : S_FIND;
                end
            end
            S_FIND:
            begin
                unique case (cmd_reg)
                    CMD_REQUEST:
                    begin
                        if (any_hit)
                        begin
                            state_next = S_REMOVE;
                        end
                        else if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            if (out_free)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_FULL;
                                state_next  = S_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = S_INSERT;
                        end
                    end
                    CMD_CANCEL:
                    begin
                        if (any_hit)
                        begin
                            state_next = S_REMOVE;
                        end
                        else if (out_free)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_NOT_FOUND;
                            emit_tv     = {TV_W{1'b1}};
                            state_next  = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            emit_tv    = wait_tv;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_REMOVE:
            begin
                if (cmd_reg == CMD_REQUEST)
                begin
                    shift_mask = remove_mask;
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_INSERT;
                end
                else if (out_free)
                begin
                    shift_mask = remove_mask;
                    count_next = count_reg - CNT_W'(1);
                    emit       = 1'b1;
                    emit_tv    = left_tv;
                    state_next = S_IDLE;
                end
            end
            S_INSERT:
            begin
                if (out_free)
                begin
                    insert     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    emit       = 1'b1;
                    emit_tv    = {1'b0, when_reg};
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (cell_flags[0].due)
                    begin
                        emit_tv    = {1'b0, cell_dl[0]};
                        emit_key   = cell_key[0];
                        emit_last  = tick_last;
                        shift_mask = '1;
                        count_next = count_reg - CNT_W'(1);
                        pop_next   = pop_reg + POP_W'(1);
                        if (tick_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        emit_status = ST_NONE_DUE;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pop_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pop_reg   <= pop_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= cmd_t'(command);
            key_reg   <= timer_key;
            when_reg  <= when_in;
            now_reg   <= now_secs;
            delay_reg <= delay_secs;
        end
        if (state_reg == S_FIND)
        begin
            match_reg  <= hit_vec;
            sel_dl_reg <= sel_dl;
        end
        if (emit)
        begin
            status_reg  <= emit_status;
            tv_reg      <= emit_tv;
            exp_key_reg <= emit_key;
            last_reg    <= emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign time_value  = tv_reg;
    assign expired_key = exp_key_reg;
    assign last        = last_reg;

endmodule

[design/stq_cell.sv]
// One slot of the timer chain: holds a deadline and key, shifts to or from
// its neighbors. Depends on stq_pkg.
module stq_cell (
    input  logic                      clk,
    input  stq_pkg::stq_bcast_t       bcast,
    input  logic                      shift_down,
    input  logic                      occ,
    input  logic                      prev_occ,
    input  logic                      prev_lt,
    input  logic [stq_pkg::DL_W-1:0]  prev_dl,
    input  logic [stq_pkg::KEY_W-1:0] prev_key,
    input  logic [stq_pkg::DL_W-1:0]  next_dl,
    input  logic [stq_pkg::KEY_W-1:0] next_key,
    output stq_pkg::stq_flags_t       flags,
    output logic [stq_pkg::DL_W-1:0]  dl,
    output logic [stq_pkg::KEY_W-1:0] key
);
    import stq_pkg::*;

    logic [DL_W-1:0]  dl_reg;
    logic [DL_W-1:0]  dl_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;

    always_comb
    begin
        flags.hit = occ && (key_reg == bcast.find_key);
        flags.lt  = occ && (bcast.new_dl < dl_reg);
        flags.due = occ && (dl_reg <= {1'b0, bcast.now});
    end

    always_comb
    begin
        dl_next  = dl_reg;
        key_next = key_reg;
        if (shift_down)
        begin
            dl_next  = next_dl;
            key_next = next_key;
        end
        else if (bcast.insert)
        begin
            if (prev_lt)
            begin
                dl_next  = prev_dl;
                key_next = prev_key;
            end
            else if (flags.lt || (!occ && prev_occ))
            begin
                dl_next  = bcast.new_dl;
                key_next = bcast.new_key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg  <= dl_next;
        key_reg <= key_next;
    end

    assign dl  = dl_reg;
    assign key = key_reg;

endmodule

[sim/tb_sorted_timer_queue.sv]
// Self-checking bench for sorted_timer_queue: random and directed timer items,
// predicted by a deadline ledger class and checked result by result.
// Depends on stq_pkg and the sorted_timer_queue RTL.
module tb_sorted_timer_queue;
    import stq_pkg::*;

    typedef struct {
        status_t           status;
        logic [TV_W-1:0]   tv;
        logic [KEY_W-1:0]  key;
        logic              last;
    } timer_result_t;

    class deadline_ledger;
        logic [DL_W-1:0]  slot_dl[QUEUE_DEPTH];
        logic [KEY_W-1:0] slot_key[QUEUE_DEPTH];
        int               held = 0;
        timer_result_t    awaited[$];
        int               errors = 0;

        function int find_slot(logic [KEY_W-1:0] key);
            for (int i = 0; i < held; i++)
                if (slot_key[i] == key)
                    return i;
            return -1;
        endfunction

        function void drop_slot(int pos);
            for (int i = pos; i + 1 < held; i++)
            begin
                slot_dl[i] = slot_dl[i + 1];
                slot_key[i] = slot_key[i + 1];
            end
            held--;
        endfunction

        function void push_result(status_t st, longint tv, logic [KEY_W-1:0] key, logic lst);
            timer_result_t r;
            r.status = st;
            r.tv = tv[TV_W-1:0];
            r.key = key;
            r.last = lst;
            awaited.push_back(r);
        endfunction

        function void note_item(cmd_t cmd, logic [KEY_W-1:0] key, logic [DELAY_W-1:0] delay,
                                logic [TIME_W-1:0] now);
            longint dv;
            longint nv;
            longint when;
            longint left;
            int pos;
            int n;
            dv = $signed(delay);
            nv = now;
            case (cmd)
                CMD_REQUEST:
                begin
                    pos = find_slot(key);
                    if (pos >= 0)
                        drop_slot(pos);
                    else if (held >= QUEUE_DEPTH)
                    begin
                        push_result(ST_FULL, 0, '0, 1'b1);
                        return;
                    end
                    when = nv + ((dv < 0) ? 0 : dv);
                    pos = 0;
                    while (pos < held && !(when < longint'(slot_dl[pos])))
                        pos++;
                    for (int i = held; i > pos; i--)
                    begin
                        slot_dl[i] = slot_dl[i - 1];
                        slot_key[i] = slot_key[i - 1];
                    end
                    slot_dl[pos] = when[DL_W-1:0];
                    slot_key[pos] = key;
                    held++;
                    push_result(ST_OK, when, '0, 1'b1);
                end
                CMD_CANCEL:
                begin
                    pos = find_slot(key);
                    if (pos < 0)
                        push_result(ST_NOT_FOUND, -1, '0, 1'b1);
                    else
                    begin
                        left = longint'(slot_dl[pos]) - nv;
                        if (left < 0)
                            left = 0;
                        drop_slot(pos);
                        push_result(ST_OK, left, '0, 1'b1);
                    end
                end
                CMD_TICK:
                begin
                    n = 0;
                    while (n < MAX_RESULTS && held > 0 && longint'(slot_dl[0]) <= nv)
                    begin
                        push_result(ST_OK, longint'(slot_dl[0]), slot_key[0], 1'b0);
                        drop_slot(0);
                        n++;
                    end
                    if (n == 0)
                        push_result(ST_NONE_DUE, 0, '0, 1'b1);
                    else
                        awaited[awaited.size() - 1].last = 1'b1;
                end
                default:
                begin
                    if (held > 0)
                    begin
                        left = longint'(slot_dl[0]) - nv;
                        if (left < 0)
                            left = 0;
                        else if (dv >= 0 && left > dv)
                            left = dv;
                    end
                    else
                        left = (dv < 0) ? -1 : dv;
                    push_result(ST_OK, left, '0, 1'b1);
                end
            endcase
        endfunction

        function void check_result(logic [ST_W-1:0] st, logic [TV_W-1:0] tv,
                                   logic [KEY_W-1:0] key, logic lst);
            timer_result_t e;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result status %0d time_value %0d key %h last %b",
                         $time, st, $signed(tv), key, lst);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (st !== e.status)
            begin
                $display("%0t: status expected %0d, actual %0d", $time, e.status, st);
                errors++;
            end
            if (tv !== e.tv)
            begin
                $display("%0t: time_value expected %0d, actual %0d", $time,
                         $signed(e.tv), $signed(tv));
                errors++;
            end
            if (key !== e.key)
            begin
                $display("%0t: expired_key expected %h, actual %h", $time, e.key, key);
                errors++;
            end
            if (lst !== e.last)
            begin
                $display("%0t: last expected %b, actual %b", $time, e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [CMD_W-1:0]         command = CMD_REQUEST;
    logic [KEY_W-1:0]         timer_key = '0;
    logic signed [DELAY_W-1:0] delay_secs = '0;
    logic [TIME_W-1:0]        now_secs = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [ST_W-1:0]          status;
    logic signed [TV_W-1:0]   time_value;
    logic [KEY_W-1:0]         expired_key;
    logic                     last;

    bit in_fast = 1'b0;
    bit out_fast = 1'b0;

    deadline_ledger ledger = new;

    sorted_timer_queue uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .timer_key   (timer_key),
        .delay_secs  (delay_secs),
        .now_secs    (now_secs),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .time_value  (time_value),
        .expired_key (expired_key),
        .last        (last)
    );

    always #4 clk = ~clk;

    task automatic send_item(cmd_t cmd, logic [KEY_W-1:0] key, logic [DELAY_W-1:0] delay,
                             logic [TIME_W-1:0] now);
        int gap;
        gap = in_fast ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        timer_key <= key;
        delay_secs <= delay;
        now_secs <= now;
        do
            @(posedge clk);
        while (!in_ready);
        ledger.note_item(cmd, key, delay, now);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (ledger.awaited.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    initial
    begin
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = out_fast ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready)
            ledger.check_result(status, time_value, expired_key, last);
    end

    initial
    begin
        logic [TIME_W-1:0]  cur_now;
        logic [DELAY_W-1:0] dly;
        logic [KEY_W-1:0]   key;
        int pick;
        int r;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(CMD_WAIT, 16'h0000, 32'hFFFF_FFFF, 32'd0);
        send_item(CMD_TICK, 16'h0000, 32'd0, 32'd0);
        send_item(CMD_CANCEL, 16'h1234, 32'd0, 32'd0);
        send_item(CMD_REQUEST, 16'h0000, 32'd0, 32'd0);
        send_item(CMD_REQUEST, 16'hFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_REQUEST, 16'd5, 32'hFFFF_FFFF, 32'd1000);
        send_item(CMD_REQUEST, 16'd5, 32'd50, 32'd1000);
        send_item(CMD_REQUEST, 16'd6, 32'd50, 32'd1000);
        for (int i = 0; i < 12; i++)
            send_item(CMD_REQUEST, KEY_W'(100 + i), 32'd7, 32'd2000);
        send_item(CMD_REQUEST, 16'd200, 32'd1, 32'd2000);
        send_item(CMD_REQUEST, 16'd100, 32'd9, 32'd2000);
        send_item(CMD_WAIT, 16'h0000, 32'hFFFF_FFFF, 32'd1000);
        send_item(CMD_CANCEL, 16'h0000, 32'd0, 32'd10);
        send_item(CMD_WAIT, 16'h0000, 32'd10, 32'd1000);
        send_item(CMD_CANCEL, 16'd6, 32'd0, 32'd1020);
        send_item(CMD_TICK, 16'h0000, 32'd0, 32'd2009);
        drain_results();

        for (int phase = 0; phase < 8; phase++)
        begin
            in_fast = (phase == 2 || phase == 5);
            out_fast = (phase == 3 || phase == 5);
            if (phase == 4)
                cur_now = 32'hFFFF_FF00;
            else if (phase % 2 == 1)
                cur_now = $urandom;
            else
                cur_now = $urandom_range(0, 5000);
            repeat (48)
            begin
                cur_now += $urandom_range(0, 6);
                pick = $urandom_range(0, 99);
                r = $urandom_range(0, 9);
                key = KEY_W'(32'h0100 + $urandom_range(0, 19));
                if (pick < 10)
                    send_item(cmd_t'($urandom_range(0, 3)), KEY_W'($urandom), $urandom,
                              $urandom);
                else if (pick < 45)
                begin
                    if (r == 0)
                        dly = 32'h8000_0000 | $urandom;
                    else if (r == 1)
                        dly = $urandom;
                    else
                        dly = $urandom_range(0, 40);
                    send_item(CMD_REQUEST, key, dly, cur_now);
                end
                else if (pick < 60)
                    send_item(CMD_CANCEL, key, $urandom, cur_now);
                else if (pick < 80)
                    send_item(CMD_TICK, key, $urandom, cur_now);
                else
                begin
                    if (r == 0)
                        dly = 32'hFFFF_FFFF;
                    else if (r == 1)
                        dly = $urandom;
                    else
                        dly = $urandom_range(0, 60);
                    send_item(CMD_WAIT, key, dly, cur_now);
                end
            end
            drain_results();
        end

        repeat (20) @(posedge clk);
        if (ledger.errors == 0 && ledger.awaited.size() == 0)
            $display("tb_sorted_timer_queue passed");
        else
            $display("tb_sorted_timer_queue failed");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("tb_sorted_timer_queue failed");
        $finish;
    end

endmodule

[sorted_timer_queue.f]
design/stq_pkg.sv
design/stq_cell.sv
design/sorted_timer_queue.sv
sim/tb_sorted_timer_queue.sv
